// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/cpc_pkg.sv =====
// types, constants and register codes of the cascaded pi converter control
package cpc_pkg;

	localparam int SAMPLE_W            = 12;
	localparam int GAIN_W              = 16;
	localparam int DUTY_W              = 9;
	localparam int TICK_W              = 8;
	localparam int TRIG_W              = DUTY_W - 1;
	localparam int CFG_W               = GAIN_W;
	localparam int IDX_W               = 3;
	localparam int VOLT_INTEGRAL_LIMIT = 262144;
	localparam int CURR_INTEGRAL_LIMIT = 245760;
	localparam int CURR_SHIFT          = 10;
	localparam int OUTER_SHIFT         = 16;
	localparam int REF_MAX             = 4096;

	localparam int REF_W   = $clog2(REF_MAX + 1);
	localparam int ERR_W   = ((SAMPLE_W > REF_W) ? SAMPLE_W : REF_W) + 1;
	localparam int VINT_W  = $clog2(VOLT_INTEGRAL_LIMIT + 1) + 1;
	localparam int CINT_W  = $clog2(CURR_INTEGRAL_LIMIT + 1) + 1;
	localparam int PROD_BW = GAIN_W + ERR_W;
	localparam int INT_MW  = (VINT_W > CINT_W) ? VINT_W : CINT_W;
	localparam int MUL_A_W = ((PROD_BW > INT_MW) ? PROD_BW : INT_MW) + 1;
	localparam int MUL_P_W = MUL_A_W + 1 + GAIN_W;
	localparam int CNT_W   = $clog2(GAIN_W);

	localparam logic [SAMPLE_W-1:0] RST_SETPOINT  = SAMPLE_W'(450);
	localparam logic [GAIN_W-1:0]   RST_VOLT_KP   = GAIN_W'(10);
	localparam logic [GAIN_W-1:0]   RST_VOLT_KI   = GAIN_W'(70);
	localparam logic [GAIN_W-1:0]   RST_CURR_KP   = GAIN_W'(40);
	localparam logic [GAIN_W-1:0]   RST_CURR_KI   = GAIN_W'(10);
	localparam logic [DUTY_W-1:0]   RST_DUTY_LIM  = DUTY_W'(300);
	localparam logic [TICK_W-1:0]   RST_OUTER_DIV = TICK_W'(20);
	localparam logic [REF_W-1:0]    REF_MAX_C     = REF_W'(REF_MAX);

	typedef enum logic [IDX_W-1:0] {
		REG_SETPOINT  = 3'd0,
		REG_VOLT_KP   = 3'd1,
		REG_VOLT_KI   = 3'd2,
		REG_CURR_KP   = 3'd3,
		REG_CURR_KI   = 3'd4,
		REG_DUTY_LIM  = 3'd5,
		REG_OUTER_DIV = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] setpoint;
		logic [GAIN_W-1:0]   volt_kp;
		logic [GAIN_W-1:0]   volt_ki;
		logic [GAIN_W-1:0]   curr_kp;
		logic [GAIN_W-1:0]   curr_ki;
		logic [DUTY_W-1:0]   duty_limit;
		logic [TICK_W-1:0]   outer_divide;
	} cfg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_V_INT,
		S_V_PROP,
		S_V_SCALE,
		S_C_ERR,
		S_C_INT,
		S_C_PROP,
		S_OUT
	} state_t;

endpackage

// ===== rtl/cpc_cfg_regs.sv =====
// configuration register file with write decode
module cpc_cfg_regs import cpc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	output cfg_t             cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.setpoint     <= RST_SETPOINT;
			cfg_q.volt_kp      <= RST_VOLT_KP;
			cfg_q.volt_ki      <= RST_VOLT_KI;
			cfg_q.curr_kp      <= RST_CURR_KP;
			cfg_q.curr_ki      <= RST_CURR_KI;
			cfg_q.duty_limit   <= RST_DUTY_LIM;
			cfg_q.outer_divide <= RST_OUTER_DIV;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_SETPOINT:  cfg_q.setpoint     <= cfg_data[SAMPLE_W-1:0];
				REG_VOLT_KP:   cfg_q.volt_kp      <= cfg_data[GAIN_W-1:0];
				REG_VOLT_KI:   cfg_q.volt_ki      <= cfg_data[GAIN_W-1:0];
				REG_CURR_KP:   cfg_q.curr_kp      <= cfg_data[GAIN_W-1:0];
				REG_CURR_KI:   cfg_q.curr_ki      <= cfg_data[GAIN_W-1:0];
				REG_DUTY_LIM:  cfg_q.duty_limit   <= cfg_data[DUTY_W-1:0];
				REG_OUTER_DIV: cfg_q.outer_divide <= cfg_data[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/cpc_serial_mult.sv =====
// bit-serial shift-add multiplier, signed multiplicand by unsigned gain
`include "assert_macros.svh"

module cpc_serial_mult import cpc_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [MUL_A_W-1:0] a,
	input  logic [GAIN_W-1:0]         b,
	output logic                      busy,
	output logic                      done,
	output logic signed [MUL_P_W-1:0] product
);

	logic                      busy_q;
	logic                      done_q;
	logic [CNT_W-1:0]          cnt_q;
	logic signed [MUL_A_W-1:0] a_q;
	logic signed [MUL_A_W:0]   hi_q;
	logic [GAIN_W-1:0]         lo_q;
	logic signed [MUL_A_W:0]   sum;

	// add the multiplicand when the low bit of the gain is set
	assign sum = hi_q + (lo_q[0] ? (MUL_A_W + 1)'(a_q) : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(GAIN_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			hi_q <= {sum[MUL_A_W], sum[MUL_A_W:1]};
			lo_q <= {sum[0], lo_q[GAIN_W-1:1]};
		end else if (start) begin
			a_q  <= a;
			hi_q <= '0;
			lo_q <= b;
		end
	end

	assign busy    = busy_q;
	assign done    = done_q;
	assign product = {hi_q, lo_q};

	`ASSERT_NEXT(a_start_runs, clk, arst_n, start && !busy_q, busy_q, "start did not launch")
	`ASSERT_IMPLIES(a_done_after_run, clk, arst_n, done_q, $past(busy_q), "done without run")
	`ASSERT_IMPLIES(a_no_overlap, clk, arst_n, done_q, !busy_q, "done while running")

endmodule

// ===== rtl/cascaded_pi_converter_control.sv =====
// cascaded pi voltage and current control: sequencer and datapath
// one item at a time: the next item is accepted only in idle, once the previous result
// has been loaded into the output register, which waits for out_ready while still full
// items are paced by one shared bit-serial multiplier (2 or 5 products per item)
// a finished result waits in the output register while the next item is taken
// async reset clears integrators, current target, tick counter and loads default registers
`include "assert_macros.svh"

module cascaded_pi_converter_control import cpc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [SAMPLE_W-1:0] out_voltage,
	input  logic [SAMPLE_W-1:0] in_voltage,
	input  logic [SAMPLE_W-1:0] load_current,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [DUTY_W-1:0]   duty,
	output logic [TRIG_W-1:0]   trigger_point,
	output logic [REF_W-1:0]    current_reference,
	output logic                outer_updated
);

	localparam logic signed [MUL_A_W-1:0] VLIM_A = MUL_A_W'(VOLT_INTEGRAL_LIMIT);
	localparam logic signed [MUL_A_W-1:0] CLIM_A = MUL_A_W'(CURR_INTEGRAL_LIMIT);
	localparam logic signed [VINT_W-1:0]  VLIM_V = VINT_W'(VOLT_INTEGRAL_LIMIT);
	localparam logic signed [CINT_W-1:0]  CLIM_C = CINT_W'(CURR_INTEGRAL_LIMIT);

	cfg_t cfg;

	state_t state_q;
	state_t state_d;

	logic                      mul_start;
	logic signed [MUL_A_W-1:0] mul_a;
	logic [GAIN_W-1:0]         mul_b;
	logic                      mul_busy;
	logic                      mul_done;
	logic signed [MUL_P_W-1:0] mul_prod;

	logic                      accept;
	logic                      out_load;

	logic [TICK_W-1:0]         tick_q;
	logic                      outer_q;
	logic signed [ERR_W-1:0]   ev_q;
	logic signed [ERR_W-1:0]   ei_q;
	logic [SAMPLE_W-1:0]       vin_q;
	logic [SAMPLE_W-1:0]       iload_q;
	logic signed [VINT_W-1:0]  vint_q;
	logic signed [CINT_W-1:0]  cint_q;
	logic [REF_W-1:0]          target_q;
	logic signed [MUL_A_W-1:0] psum_q;
	logic signed [MUL_A_W-1:0] acc_q;

	logic                      out_valid_q;
	logic [DUTY_W-1:0]         duty_q;
	logic [REF_W-1:0]          ref_out_q;
	logic                      outer_out_q;

	logic signed [MUL_A_W-1:0] prod_lo;
	logic signed [MUL_A_W-1:0] vint_sum;
	logic signed [MUL_A_W-1:0] cint_sum;
	logic signed [MUL_A_W-1:0] vint_clip;
	logic signed [MUL_A_W-1:0] cint_clip;
	logic signed [MUL_P_W-1:0] ref_shift;
	logic [REF_W-1:0]          ref_clip;
	logic signed [MUL_A_W-1:0] duty_shift;
	logic [DUTY_W-1:0]         duty_clip;

	cpc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	cpc_serial_mult u_mult (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.busy    (mul_busy),
		.done    (mul_done),
		.product (mul_prod)
	);

	// integrator updates and output clamps
	always_comb begin
		prod_lo  = mul_prod[MUL_A_W-1:0];
		vint_sum = prod_lo + MUL_A_W'(vint_q);
		cint_sum = prod_lo + MUL_A_W'(cint_q);

		if (vint_sum > VLIM_A) begin
			vint_clip = VLIM_A;
		end else if (vint_sum < -VLIM_A) begin
			vint_clip = -VLIM_A;
		end else begin
			vint_clip = vint_sum;
		end

		if (cint_sum > CLIM_A) begin
			cint_clip = CLIM_A;
		end else if (cint_sum < -CLIM_A) begin
			cint_clip = -CLIM_A;
		end else begin
			cint_clip = cint_sum;
		end

		ref_shift = mul_prod >>> OUTER_SHIFT;
		if (mul_prod[MUL_P_W-1]) begin
			ref_clip = '0;
		end else if (ref_shift > MUL_P_W'(REF_MAX)) begin
			ref_clip = REF_MAX_C;
		end else begin
			ref_clip = ref_shift[REF_W-1:0];
		end

		duty_shift = acc_q >>> CURR_SHIFT;
		if (acc_q[MUL_A_W-1]) begin
			duty_clip = '0;
		end else if (duty_shift > MUL_A_W'(cfg.duty_limit)) begin
			duty_clip = cfg.duty_limit;
		end else begin
			duty_clip = duty_shift[DUTY_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		mul_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		out_load  = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = (tick_q == cfg.outer_divide) ? S_V_INT : S_C_ERR;
				end
			end
			S_V_INT: begin
				mul_start = !mul_busy && !mul_done;
				mul_a     = MUL_A_W'(ev_q);
				mul_b     = cfg.volt_ki;
				if (mul_done) begin
					state_d = S_V_PROP;
				end
			end
			S_V_PROP: begin
				mul_start = !mul_busy && !mul_done;
				mul_a     = MUL_A_W'(ev_q);
				mul_b     = cfg.volt_kp;
				if (mul_done) begin
					state_d = S_V_SCALE;
				end
			end
			S_V_SCALE: begin
				mul_start = !mul_busy && !mul_done;
				mul_a     = psum_q;
				mul_b     = GAIN_W'(vin_q);
				if (mul_done) begin
					state_d = S_C_ERR;
				end
			end
			S_C_ERR: begin
				state_d = S_C_INT;
			end
			S_C_INT: begin
				mul_start = !mul_busy && !mul_done;
				mul_a     = MUL_A_W'(ei_q);
				mul_b     = cfg.curr_ki;
				if (mul_done) begin
					state_d = S_C_PROP;
				end
			end
			S_C_PROP: begin
				mul_start = !mul_busy && !mul_done;
				mul_a     = MUL_A_W'(ei_q);
				mul_b     = cfg.curr_kp;
				if (mul_done) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign accept = in_valid && in_ready;

	// loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q   <= '0;
			vint_q   <= '0;
			cint_q   <= '0;
			target_q <= '0;
		end else begin
			if (accept) begin
				tick_q <= (tick_q == cfg.outer_divide) ? '0 : tick_q + 1'b1;
			end
			if (state_q == S_V_INT && mul_done) begin
				vint_q <= vint_clip[VINT_W-1:0];
			end
			if (state_q == S_V_SCALE && mul_done) begin
				target_q <= ref_clip;
			end
			if (state_q == S_C_INT && mul_done) begin
				cint_q <= cint_clip[CINT_W-1:0];
			end
		end
	end

	// per-item working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			outer_q <= (tick_q == cfg.outer_divide);
			ev_q    <= $signed({{(ERR_W - SAMPLE_W){1'b0}}, cfg.setpoint})
				- $signed({{(ERR_W - SAMPLE_W){1'b0}}, out_voltage});
			vin_q   <= in_voltage;
			iload_q <= load_current;
		end
		if (state_q == S_V_PROP && mul_done) begin
			psum_q <= prod_lo + MUL_A_W'(vint_q);
		end
		if (state_q == S_C_ERR) begin
			ei_q <= $signed({{(ERR_W - REF_W){1'b0}}, target_q})
				- $signed({{(ERR_W - SAMPLE_W){1'b0}}, iload_q});
		end
		if (state_q == S_C_PROP && mul_done) begin
			acc_q <= prod_lo + MUL_A_W'(cint_q);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			duty_q      <= duty_clip;
			ref_out_q   <= target_q;
			outer_out_q <= outer_q;
		end
	end

	assign out_valid         = out_valid_q;
	assign duty              = duty_q;
	assign trigger_point     = duty_q[DUTY_W-1:1];
	assign current_reference = ref_out_q;
	assign outer_updated     = outer_out_q;

	`ASSERT_ALWAYS(a_vint_range, clk, arst_n, (vint_q <= VLIM_V) && (vint_q >= -VLIM_V), "voltage integrator out of range")
	`ASSERT_ALWAYS(a_cint_range, clk, arst_n, (cint_q <= CLIM_C) && (cint_q >= -CLIM_C), "current integrator out of range")
	`ASSERT_IMPLIES(a_ref_range, clk, arst_n, out_valid_q, ref_out_q <= REF_MAX_C, "current reference above limit")
	`ASSERT_IMPLIES(a_start_free, clk, arst_n, mul_start, !mul_busy && !mul_done, "multiplier started while in use")

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// testbench of the cascaded pi converter control: directed ticks, random ticks, scoreboard
module tb;
	import cpc_pkg::*;

	localparam logic [IDX_W-1:0] REG_NONE = 3'd7;
	localparam int IDLE_LIMIT    = 3000;
	localparam int SETTLE_CYCLES = 120;
	localparam int LONG_HOLD     = 400;

	typedef struct packed {
		logic [DUTY_W-1:0] duty;
		logic [TRIG_W-1:0] trig;
		logic [REF_W-1:0]  cur_ref;
		logic              outer;
	} tick_out_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] vo;
		logic [SAMPLE_W-1:0] vi;
		logic [SAMPLE_W-1:0] il;
		logic                typed;
		tick_out_t           known;
	} dir_row_t;

	typedef logic [6:0][CFG_W-1:0] cfg_words_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [IDX_W-1:0]    cfg_index;
	logic [CFG_W-1:0]    cfg_data;
	logic                in_valid;
	logic                in_ready;
	logic [SAMPLE_W-1:0] out_voltage;
	logic [SAMPLE_W-1:0] in_voltage;
	logic [SAMPLE_W-1:0] load_current;
	logic                out_valid;
	logic                out_ready;
	logic [DUTY_W-1:0]   duty;
	logic [TRIG_W-1:0]   trigger_point;
	logic [REF_W-1:0]    current_reference;
	logic                outer_updated;

	cfg_t                ctl_cfg;
	logic [TICK_W-1:0]   tick_cnt;
	longint              volt_int;
	longint              curr_int;
	logic [REF_W-1:0]    target;

	tick_out_t pending[$];
	int        mismatches  = 0;
	int        idle_cycles = 0;
	bit        hold_req    = 1'b0;

	dir_row_t dir_rows [24] = '{
		'{12'd0,    12'd0,    12'd0,    1'b1, '{9'd0, 8'd0, 13'd0, 1'b0}},
		'{12'd0,    12'd0,    12'd4095, 1'b1, '{9'd0, 8'd0, 13'd0, 1'b0}},
		'{12'd4095, 12'd4095, 12'd0,    1'b0, '0},
		'{12'd4095, 12'd0,    12'd4095, 1'b0, '0},
		'{12'd450,  12'd2048, 12'd0,    1'b0, '0},
		'{12'd2048, 12'd1,    12'd100,  1'b0, '0},
		'{12'd1,    12'd4095, 12'd2047, 1'b0, '0},
		'{12'h555,  12'haaa,  12'h555,  1'b0, '0},
		'{12'haaa,  12'h555,  12'haaa,  1'b0, '0},
		'{12'd449,  12'd3000, 12'd10,   1'b0, '0},
		'{12'd451,  12'd3000, 12'd10,   1'b0, '0},
		'{12'd0,    12'd4095, 12'd0,    1'b0, '0},
		'{12'd4095, 12'd4095, 12'd4095, 1'b0, '0},
		'{12'd100,  12'd200,  12'd300,  1'b0, '0},
		'{12'd300,  12'd4095, 12'd0,    1'b0, '0},
		'{12'd12,   12'd34,   12'd56,   1'b0, '0},
		'{12'd1000, 12'd1000, 12'd1000, 1'b0, '0},
		'{12'd4000, 12'd4000, 12'd4000, 1'b0, '0},
		'{12'd450,  12'd0,    12'd1,    1'b0, '0},
		'{12'd7,    12'd8,    12'd9,    1'b0, '0},
		'{12'd300,  12'd4095, 12'd700,  1'b0, '0},
		'{12'd300,  12'd4095, 12'd700,  1'b0, '0},
		'{12'd4095, 12'd0,    12'd749,  1'b0, '0},
		'{12'd0,    12'd4095, 12'd800,  1'b0, '0}
	};

	cascaded_pi_converter_control dut (.*);

	always #10 clk = ~clk;

	function automatic longint clamp_to(longint v, longint lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	function automatic tick_out_t control_tick(logic [SAMPLE_W-1:0] vo, logic [SAMPLE_W-1:0] vi,
			logic [SAMPLE_W-1:0] il);
		longint    err;
		longint    acc;
		longint    val;
		tick_out_t r;
		r.outer = 1'b0;
		if (tick_cnt == ctl_cfg.outer_divide) begin
			r.outer  = 1'b1;
			tick_cnt = '0;
			err      = longint'(ctl_cfg.setpoint) - longint'(vo);
			volt_int = clamp_to(volt_int + longint'(ctl_cfg.volt_ki) * err, VOLT_INTEGRAL_LIMIT);
			acc      = (longint'(ctl_cfg.volt_kp) * err + volt_int) * longint'(vi);
			val      = acc >>> OUTER_SHIFT;
			if (val > REF_MAX)
				val = REF_MAX;
			else if (val < 0)
				val = 0;
			target = REF_W'(val);
		end else begin
			tick_cnt = tick_cnt + 1'b1;
		end
		err      = longint'(target) - longint'(il);
		curr_int = clamp_to(curr_int + longint'(ctl_cfg.curr_ki) * err, CURR_INTEGRAL_LIMIT);
		val      = (longint'(ctl_cfg.curr_kp) * err + curr_int) >>> CURR_SHIFT;
		if (val < 0)
			val = 0;
		if (val > longint'(ctl_cfg.duty_limit))
			val = longint'(ctl_cfg.duty_limit);
		r.duty    = DUTY_W'(val);
		r.trig    = TRIG_W'(val >>> 1);
		r.cur_ref = target;
		return r;
	endfunction

	function automatic void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		case (idx)
			REG_SETPOINT:  ctl_cfg.setpoint     = data[SAMPLE_W-1:0];
			REG_VOLT_KP:   ctl_cfg.volt_kp      = data[GAIN_W-1:0];
			REG_VOLT_KI:   ctl_cfg.volt_ki      = data[GAIN_W-1:0];
			REG_CURR_KP:   ctl_cfg.curr_kp      = data[GAIN_W-1:0];
			REG_CURR_KI:   ctl_cfg.curr_ki      = data[GAIN_W-1:0];
			REG_DUTY_LIM:  ctl_cfg.duty_limit   = data[DUTY_W-1:0];
			REG_OUTER_DIV: ctl_cfg.outer_divide = data[TICK_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic logic [SAMPLE_W-1:0] any_sample();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	// mostly close to the operating point so the loops leave saturation
	function automatic logic [SAMPLE_W-1:0] near_value(int center);
		int v;
		if ($urandom_range(0, 2) == 0)
			return any_sample();
		v = center + int'($urandom_range(0, 128)) - 64;
		if (v < 0)
			v = 0;
		if (v > 4095)
			v = 4095;
		return SAMPLE_W'(v);
	endfunction

	function automatic logic [CFG_W-1:0] gain_word();
		return CFG_W'($urandom_range(0, 65535) >> $urandom_range(0, 15));
	endfunction

	task automatic write_config(input cfg_words_t words, input bit junk);
		for (int k = 0; k < 7; k++) begin
			cfg_we    <= 1'b1;
			cfg_index <= reg_idx_t'(k);
			cfg_data  <= words[k];
			@(posedge clk);
			set_reg(reg_idx_t'(k), words[k]);
		end
		if (junk) begin
			cfg_index <= REG_NONE;
			cfg_data  <= '1;
			@(posedge clk);
			set_reg(REG_NONE, '1);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_tick(input logic [SAMPLE_W-1:0] vo, input logic [SAMPLE_W-1:0] vi,
			input logic [SAMPLE_W-1:0] il, input bit typed, input tick_out_t known);
		tick_out_t predicted;
		in_valid     <= 1'b1;
		out_voltage  <= vo;
		in_voltage   <= vi;
		load_current <= il;
		do @(posedge clk); while (!in_ready);
		predicted = control_tick(vo, vi, il);
		pending.push_back(typed ? known : predicted);
	endtask

	task automatic drain();
		while (pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic random_ticks(input int count, input int hold_at, input int pause_at);
		int burst;
		int gap;
		burst = $urandom_range(1, 24);
		for (int n = 0; n < count; n++) begin
			if (n == hold_at)
				hold_req = 1'b1;
			if (n == pause_at) begin
				in_valid <= 1'b0;
				@(posedge clk);
				while (pending.size() != 0)
					@(posedge clk);
			end
			send_tick(near_value(int'(ctl_cfg.setpoint)), any_sample(), near_value(int'(target)),
				1'b0, '0);
			burst--;
			if (burst == 0) begin
				burst = $urandom_range(1, 24);
				gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 100);
				if (gap != 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
		in_valid <= 1'b0;
	endtask

	initial begin
		cfg_words_t w;
		dir_row_t   row;
		arst_n       <= 1'b0;
		cfg_we       <= 1'b0;
		cfg_index    <= '0;
		cfg_data     <= '0;
		in_valid     <= 1'b0;
		out_voltage  <= '0;
		in_voltage   <= '0;
		load_current <= '0;
		ctl_cfg  = '{RST_SETPOINT, RST_VOLT_KP, RST_VOLT_KI, RST_CURR_KP, RST_CURR_KI,
			RST_DUTY_LIM, RST_OUTER_DIV};
		tick_cnt = '0;
		volt_int = 0;
		curr_int = 0;
		target   = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[n]) begin
			row = dir_rows[n];
			send_tick(row.vo, row.vi, row.il, row.typed, row.known);
		end
		in_valid <= 1'b0;
		drain();

		// all ones, divider below the running count so the tick counter wraps
		w = '1;
		w[REG_OUTER_DIV] = CFG_W'(1);
		write_config(w, 1'b1);
		random_ticks(280, -1, -1);
		drain();

		w = '0;
		write_config(w, 1'b0);
		random_ticks(40, -1, -1);
		drain();

		for (int p = 0; p < 6; p++) begin
			w[REG_SETPOINT]  = CFG_W'($urandom);
			w[REG_VOLT_KP]   = gain_word();
			w[REG_VOLT_KI]   = gain_word();
			w[REG_CURR_KP]   = gain_word();
			w[REG_CURR_KI]   = gain_word();
			w[REG_DUTY_LIM]  = CFG_W'($urandom);
			w[REG_OUTER_DIV] = {8'($urandom), 8'($urandom_range(0, 6))};
			write_config(w, 1'b0);
			random_ticks(80, (p == 1) ? 20 : -1, (p == 2) ? 40 : -1);
			drain();
		end

		w[REG_OUTER_DIV] = CFG_W'(255);
		write_config(w, 1'b0);
		random_ticks(60, -1, -1);
		drain();

		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		int mode;
		int left;
		mode = 0;
		left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				if (left == 0) begin
					mode = $urandom_range(0, 2);
					left = $urandom_range(30, 300);
				end
				left--;
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 3) == 0);
					default: out_ready <= 1'($urandom_range(0, 1));
				endcase
			end
		end
	end

	always @(posedge clk) begin
		tick_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending.size() == 0) begin
				$display("%0t: item with no expectation, duty %0d", $time, duty);
				mismatches++;
			end else begin
				want = pending.pop_front();
				if (duty !== want.duty) begin
					$display("%0t: duty expected %0d actual %0d", $time, want.duty, duty);
					mismatches++;
				end
				if (trigger_point !== want.trig) begin
					$display("%0t: trigger_point expected %0d actual %0d", $time, want.trig,
						trigger_point);
					mismatches++;
				end
				if (current_reference !== want.cur_ref) begin
					$display("%0t: current_reference expected %0d actual %0d", $time,
						want.cur_ref, current_reference);
					mismatches++;
				end
				if (outer_updated !== want.outer) begin
					$display("%0t: outer_updated expected %0d actual %0d", $time, want.outer,
						outer_updated);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

// ===== cascaded_pi_converter_control.f =====
+incdir+rtl
rtl/cpc_pkg.sv
rtl/cpc_cfg_regs.sv
rtl/cpc_serial_mult.sv
rtl/cascaded_pi_converter_control.sv
test/tb.sv
